// ----- src/subarray_target_sum_counter_assert.svh -----
// Assertion macros used by the top-level RTL file of the subarray target sum counter.
`ifndef SUBARRAY_TARGET_SUM_COUNTER_ASSERT_SVH
`define SUBARRAY_TARGET_SUM_COUNTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSTC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sstc_pkg.sv -----
`default_nettype none

package sstc_pkg;

    localparam int MAX_LEN_DEF = 256;
    localparam int ELEM_W      = 16;
    localparam int SUM_W       = 24;
    localparam int COUNT_W     = 16;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic REG_TARGET_SUM = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic update;
        logic shift;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- src/sstc_cell.sv -----
`default_nettype none

module sstc_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire sstc_pkg::t_cell_ctl                 i_ctl,
    input  wire logic signed [sstc_pkg::ELEM_W-1:0]  i_element,
    input  wire logic        [sstc_pkg::SUM_W-1:0]   i_target,
    input  wire logic        [sstc_pkg::SUM_W-1:0]   i_sum_prev,
    input  wire logic                                i_valid_prev,
    input  wire logic                                i_hit_next,
    output logic             [sstc_pkg::SUM_W-1:0]   o_sum,
    output logic                                     o_valid,
    output logic                                     o_hit
);

    logic [sstc_pkg::SUM_W-1:0] r_sum;
    logic                       r_valid;
    logic                       r_hit;
    logic [sstc_pkg::SUM_W-1:0] n_sum;

    assign n_sum = i_sum_prev
        + {{(sstc_pkg::SUM_W - sstc_pkg::ELEM_W){i_element[sstc_pkg::ELEM_W-1]}}, i_element};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else if (i_ctl.update) begin
            r_valid <= i_valid_prev;
            r_hit   <= i_valid_prev && (n_sum == i_target);
        end else if (i_ctl.shift) begin
            r_hit   <= i_hit_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.update) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum   = r_sum;
    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

// ----- src/subarray_target_sum_counter.sv -----
`default_nettype none
// Counts the contiguous subarrays whose sum equals target_sum in a stream of signed
// elements. A row of MAX_LEN cells holds the run sums; an accepted element enters the
// head cell and every run sum moves one cell along the row with the element added, all
// in the cycle of acceptance. The match flags of the cells are then shifted back to the
// head and tallied one per cycle; the next element is not taken until the flags of all
// n cells of an array now n long are tallied and the result has gone to the output
// register. An element that comes past MAX_LEN only sets the sticky overflow and skips
// the tally. The result of an element waits in an output register, so the next element
// can be taken while it is still stalled. The match count saturates at 65535.

module subarray_target_sum_counter #(
    parameter int MAX_LEN = sstc_pkg::MAX_LEN_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic        [sstc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic        [sstc_pkg::PDATA_W-1:0]  pwdata,
    output logic             [sstc_pkg::PDATA_W-1:0]  prdata,
    output logic                                      pready,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic signed [sstc_pkg::ELEM_W-1:0]   i_element,
    input  wire logic                                 i_first,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic             [sstc_pkg::COUNT_W-1:0]  o_match_count,
    output logic                                      o_overflow
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    sstc_pkg::t_state               r_state;
    sstc_pkg::t_state               n_state;
    logic [sstc_pkg::SUM_W-1:0]     r_target;
    logic [LEN_W-1:0]               r_len;
    logic [LEN_W-1:0]               r_cnt;
    logic [sstc_pkg::COUNT_W-1:0]   r_total;
    logic                           r_ovf;
    logic                           r_out_valid;
    logic [sstc_pkg::COUNT_W-1:0]   r_out_count;
    logic                           r_out_ovf;

    logic                           w_accept;
    logic [LEN_W-1:0]               w_len_eff;
    logic                           w_full;
    logic                           w_slot_free;
    logic                           w_cfg_write;
    sstc_pkg::t_cell_ctl            w_ctl;

    logic [sstc_pkg::SUM_W-1:0]     w_sum   [MAX_LEN];
    logic                           w_valid [MAX_LEN];
    logic                           w_hit   [MAX_LEN];

    assign w_accept    = i_valid && !o_stall;
    assign w_len_eff   = i_first ? '0 : r_len;
    assign w_full      = (w_len_eff == LEN_W'(MAX_LEN));
    assign w_slot_free = !r_out_valid || !i_stall;
    assign w_cfg_write = psel && penable && pwrite && pready
                         && (paddr[2] == sstc_pkg::REG_TARGET_SUM);

    assign w_ctl.update = w_accept && !w_full;
    assign w_ctl.shift  = (r_state == sstc_pkg::ST_COUNT);

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        logic [sstc_pkg::SUM_W-1:0] w_sum_prev;
        logic                       w_valid_prev;
        logic                       w_hit_next;

        if (k == 0) begin : g_head
            assign w_sum_prev   = '0;
            assign w_valid_prev = 1'b1;
        end else begin : g_body
            assign w_sum_prev   = w_sum[k-1];
            assign w_valid_prev = w_valid[k-1] && !i_first;
        end

        if (k == MAX_LEN - 1) begin : g_tail
            assign w_hit_next = 1'b0;
        end else begin : g_inner
            assign w_hit_next = w_hit[k+1];
        end

        sstc_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_element    (i_element),
            .i_target     (r_target),
            .i_sum_prev   (w_sum_prev),
            .i_valid_prev (w_valid_prev),
            .i_hit_next   (w_hit_next),
            .o_sum        (w_sum[k]),
            .o_valid      (w_valid[k]),
            .o_hit        (w_hit[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (w_cfg_write) begin
            r_target <= pwdata[sstc_pkg::SUM_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sstc_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_full ? sstc_pkg::ST_DONE : sstc_pkg::ST_COUNT;
                end
            end
            sstc_pkg::ST_COUNT: begin
                if (r_cnt == LEN_W'(1)) begin
                    n_state = sstc_pkg::ST_DONE;
                end
            end
            sstc_pkg::ST_DONE: begin
                if (w_slot_free) begin
                    n_state = sstc_pkg::ST_IDLE;
                end
            end
            default: n_state = sstc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall       = (r_state != sstc_pkg::ST_IDLE);
        o_valid       = r_out_valid;
        o_match_count = r_out_count;
        o_overflow    = r_out_ovf;
        pready        = 1'b1;
        prdata        = {{(sstc_pkg::PDATA_W - sstc_pkg::SUM_W){r_target[sstc_pkg::SUM_W-1]}},
                         r_target};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sstc_pkg::ST_IDLE;
            r_len       <= '0;
            r_cnt       <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_accept) begin
                if (i_first) begin
                    r_total <= '0;
                    r_ovf   <= 1'b0;
                end
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_len <= w_len_eff + LEN_W'(1);
                    r_cnt <= w_len_eff + LEN_W'(1);
                end
            end else if (r_state == sstc_pkg::ST_COUNT) begin
                r_cnt <= r_cnt - LEN_W'(1);
                if (w_hit[0] && (r_total != '1)) begin
                    r_total <= r_total + sstc_pkg::COUNT_W'(1);
                end
            end

            if ((r_state == sstc_pkg::ST_DONE) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == sstc_pkg::ST_DONE) && w_slot_free) begin
            r_out_count <= r_total;
            r_out_ovf   <= r_ovf;
        end
    end

`include "subarray_target_sum_counter_assert.svh"

    `SSTC_ASSERT_NOW(a_busy_stalls, i_clk, i_rst_n, r_state != sstc_pkg::ST_IDLE, o_stall, "Input taken while the cells are busy.")
    `SSTC_ASSERT_NOW(a_count_nonzero, i_clk, i_rst_n, r_state == sstc_pkg::ST_COUNT, r_cnt != '0, "Flag tally ran with no cells left.")
    `SSTC_ASSERT_NOW(a_ovf_full, i_clk, i_rst_n, r_ovf, r_len == LEN_W'(MAX_LEN), "Overflow set while the row is not full.")
    `SSTC_ASSERT_NEXT(a_accept_counts, i_clk, i_rst_n, w_accept && (i_first || (r_len != LEN_W'(MAX_LEN))), r_state == sstc_pkg::ST_COUNT, "Accepted beat did not start a tally.")

endmodule

`default_nettype wire
